FILE: hdl/sitm_pkg.sv
// Package for the staged idle timeout monitor: types, codes and the counter width.
// Used by the step logic and the top level; depends on nothing.
`default_nettype none

package sitm_pkg;

   // Width of the shared countdown register.
   localparam int unsigned CountWidth = 32;
   localparam int unsigned TimeoutWidth = 32;
   localparam int unsigned CsrIndexWidth = 2;

   typedef logic [CountWidth-1:0]   count_type;
   typedef logic [TimeoutWidth-1:0] timeout_type;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_ACT_HINT   = 3'd1,
      OP_HINT       = 3'd2,
      OP_ACT        = 3'd3,
      OP_SUPPRESS   = 3'd4
   } opcode_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_IDLE_TIMEOUT = 2'd0,
      CSR_DEEP_TIMEOUT = 2'd1,
      CSR_LOCK_TIMEOUT = 2'd2
   } csr_index_type;

   // Which countdown is running, one-hot.
   typedef enum logic [3:0] {
      STAGE_NONE = 4'b0001,
      STAGE_IDLE = 4'b0010,
      STAGE_DEEP = 4'b0100,
      STAGE_LOCK = 4'b1000
   } stage_type;

   typedef struct packed {
      count_type countdown;
      stage_type stage;
      logic      idle_flag;
      logic      deep_flag;
      logic      suppressed_flag;
   } state_type;

   typedef struct packed {
      logic idle_level;
      logic deep_idle_level;
      logic idle_changed;
      logic deep_idle_changed;
      logic lock_pulse;
      logic resume_hint;
      logic activity_seen;
   } result_type;

   typedef struct packed {
      timeout_type idle_timeout;
      timeout_type deep_timeout;
      timeout_type lock_timeout;
   } timeouts_type;

   // A timeout wider than the counter saturates at the counter's largest value.
   function automatic count_type load_value(timeout_type t);
      logic [63:0] wide;
      logic [63:0] limit;
      wide  = 64'(t);
      limit = 64'({CountWidth{1'b1}});
      if (wide > limit) begin
         load_value = {CountWidth{1'b1}};
      end else begin
         load_value = CountWidth'(wide);
      end
   endfunction

endpackage

`default_nettype wire

FILE: hdl/sitm_req_if.sv
// Input channel of the staged idle timeout monitor: valid, ready and one item.
// Depends on nothing.
`default_nettype none

interface sitm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic       suppress_value;

   modport source (output valid, output opcode, output suppress_value, input ready);
   modport sink   (input valid, input opcode, input suppress_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/sitm_rsp_if.sv
// Result channel of the staged idle timeout monitor: valid, ready and one result.
// Depends on nothing.
`default_nettype none

interface sitm_rsp_if;
   logic valid;
   logic ready;
   logic idle_level;
   logic deep_idle_level;
   logic idle_changed;
   logic deep_idle_changed;
   logic lock_pulse;
   logic resume_hint;
   logic activity_seen;

   modport source (output valid, output idle_level, output deep_idle_level,
                   output idle_changed, output deep_idle_changed, output lock_pulse,
                   output resume_hint, output activity_seen, input ready);
   modport sink   (input valid, input idle_level, input deep_idle_level,
                   input idle_changed, input deep_idle_changed, input lock_pulse,
                   input resume_hint, input activity_seen, output ready);
endinterface

`default_nettype wire

FILE: hdl/sitm_step.sv
// Next-state and result logic for one beat of the staged idle timeout monitor.
// Depends on sitm_pkg.
`default_nettype none

module sitm_step (
   input  wire logic [2:0]            opcode,
   input  wire logic                  suppress_value,
   input  wire sitm_pkg::timeouts_type timeouts,
   input  wire sitm_pkg::state_type    cur,
   output sitm_pkg::state_type         nxt,
   output sitm_pkg::result_type        result
);

   sitm_pkg::opcode_type op;
   logic                 pulse;

   assign op = sitm_pkg::opcode_type'(opcode);

   always_comb begin
      nxt   = cur;
      pulse = 1'b0;
      case (op)
         sitm_pkg::OP_TICK: begin
            if (cur.stage != sitm_pkg::STAGE_NONE) begin
               if (cur.countdown <= sitm_pkg::count_type'(1)) begin
                  nxt.countdown = '0;
                  nxt.stage     = sitm_pkg::STAGE_NONE;
                  case (cur.stage)
                     sitm_pkg::STAGE_IDLE: begin
                        if (!cur.suppressed_flag) begin
                           nxt.idle_flag = 1'b1;
                           nxt.stage     = sitm_pkg::STAGE_DEEP;
                           nxt.countdown = sitm_pkg::load_value(timeouts.deep_timeout);
                        end
                     end
                     sitm_pkg::STAGE_DEEP: begin
                        if (!cur.suppressed_flag && cur.idle_flag) begin
                           nxt.deep_flag = 1'b1;
                           nxt.stage     = sitm_pkg::STAGE_LOCK;
                           nxt.countdown = sitm_pkg::load_value(timeouts.lock_timeout);
                        end
                     end
                     sitm_pkg::STAGE_LOCK: begin
                        pulse = !cur.suppressed_flag && cur.deep_flag;
                     end
                     default: begin
                     end
                  endcase
               end else begin
                  nxt.countdown = cur.countdown - sitm_pkg::count_type'(1);
               end
            end
         end
         sitm_pkg::OP_ACT_HINT, sitm_pkg::OP_ACT: begin
            // Activity drops both flags and cancels the later stages.
            if (cur.stage inside {sitm_pkg::STAGE_DEEP, sitm_pkg::STAGE_LOCK}) begin
               nxt.stage = sitm_pkg::STAGE_NONE;
            end
            nxt.idle_flag = 1'b0;
            nxt.deep_flag = 1'b0;
            if (!cur.suppressed_flag) begin
               nxt.stage     = sitm_pkg::STAGE_IDLE;
               nxt.countdown = sitm_pkg::load_value(timeouts.idle_timeout);
            end
         end
         sitm_pkg::OP_SUPPRESS: begin
            if (suppress_value != cur.suppressed_flag) begin
               nxt.suppressed_flag = suppress_value;
               if (suppress_value) begin
                  nxt.stage     = sitm_pkg::STAGE_NONE;
                  nxt.idle_flag = 1'b0;
                  nxt.deep_flag = 1'b0;
               end else begin
                  nxt.stage     = sitm_pkg::STAGE_IDLE;
                  nxt.countdown = sitm_pkg::load_value(timeouts.idle_timeout);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.idle_level        = nxt.idle_flag;
      result.deep_idle_level   = nxt.deep_flag;
      result.idle_changed      = nxt.idle_flag ^ cur.idle_flag;
      result.deep_idle_changed = nxt.deep_flag ^ cur.deep_flag;
      result.lock_pulse        = pulse;
      result.resume_hint       = (op == sitm_pkg::OP_ACT_HINT) || (op == sitm_pkg::OP_HINT);
      result.activity_seen     = (op == sitm_pkg::OP_ACT_HINT) || (op == sitm_pkg::OP_ACT);
   end

endmodule

`default_nettype wire

FILE: hdl/staged_idle_timeout_monitor_unit.sv
// Top level of the staged idle timeout monitor: input register, state, result register.
// Depends on sitm_pkg, sitm_req_if, sitm_rsp_if and sitm_step.
//
//   Channel   Direction  Contents                                   Handshake
//   req_bus   in         opcode, suppress_value                     valid/ready
//   rsp_bus   out        idle/deep levels, changes, pulse, hints    valid/ready
//   csr_*     in         timeout writes, index 0..2, 32-bit data    write enable only
//
// Every beat passes two registers: the input register and the result register. The timer
// state is updated in the same cycle the beat moves from the first to the second, so a beat
// can enter every cycle while the result channel is not stalled.
// Reset is synchronous: the timeouts return to their defaults, the idle countdown is loaded
// and both registers are emptied. A stalled result holds in the result register while one
// more beat waits in the input register; ready drops only when both are full.
`default_nettype none

module staged_idle_timeout_monitor_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   sitm_req_if.sink                           req_bus,
   sitm_rsp_if.source                         rsp_bus,
   input  wire logic                          csr_we,
   input  wire logic [sitm_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [sitm_pkg::TimeoutWidth-1:0]  csr_wdata
);

   localparam sitm_pkg::timeout_type IdleReset = sitm_pkg::timeout_type'(120000);
   localparam sitm_pkg::timeout_type DeepReset = sitm_pkg::timeout_type'(480000);
   localparam sitm_pkg::timeout_type LockReset = sitm_pkg::timeout_type'(1200000);

   // Timeout registers.
   sitm_pkg::timeouts_type timeouts_ff, timeouts_in;

   // Input register.
   logic       req_valid_ff, req_valid_in;
   logic [2:0] opcode_ff, opcode_in;
   logic       suppress_ff, suppress_in;

   // Timer state.
   sitm_pkg::state_type state_ff, state_in, state_step;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   sitm_pkg::result_type result_ff, result_in, result_step;

   logic advance;   // the beat in the input register moves to the result register
   logic accept;

   sitm_step u_step (
      .opcode         (opcode_ff),
      .suppress_value (suppress_ff),
      .timeouts       (timeouts_ff),
      .cur            (state_ff),
      .nxt            (state_step),
      .result         (result_step)
   );

   assign advance = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || advance;
   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      timeouts_in = timeouts_ff;
      if (csr_we) begin
         case (sitm_pkg::csr_index_type'(csr_index))
            sitm_pkg::CSR_IDLE_TIMEOUT: timeouts_in.idle_timeout = csr_wdata;
            sitm_pkg::CSR_DEEP_TIMEOUT: timeouts_in.deep_timeout = csr_wdata;
            sitm_pkg::CSR_LOCK_TIMEOUT: timeouts_in.lock_timeout = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      req_valid_in = accept || (req_valid_ff && !advance);
      opcode_in    = accept ? req_bus.opcode : opcode_ff;
      suppress_in  = accept ? req_bus.suppress_value : suppress_ff;

      state_in     = advance ? state_step : state_ff;

      rsp_valid_in = advance || (rsp_valid_ff && !rsp_bus.ready);
      result_in    = advance ? result_step : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeouts_ff.idle_timeout <= IdleReset;
         timeouts_ff.deep_timeout <= DeepReset;
         timeouts_ff.lock_timeout <= LockReset;
         req_valid_ff              <= 1'b0;
         rsp_valid_ff              <= 1'b0;
         state_ff.countdown        <= sitm_pkg::load_value(IdleReset);
         state_ff.stage            <= sitm_pkg::STAGE_IDLE;
         state_ff.idle_flag        <= 1'b0;
         state_ff.deep_flag        <= 1'b0;
         state_ff.suppressed_flag  <= 1'b0;
      end else begin
         timeouts_ff  <= timeouts_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      opcode_ff   <= opcode_in;
      suppress_ff <= suppress_in;
      result_ff   <= result_in;
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.idle_level        = result_ff.idle_level;
   assign rsp_bus.deep_idle_level   = result_ff.deep_idle_level;
   assign rsp_bus.idle_changed      = result_ff.idle_changed;
   assign rsp_bus.deep_idle_changed = result_ff.deep_idle_changed;
   assign rsp_bus.lock_pulse        = result_ff.lock_pulse;
   assign rsp_bus.resume_hint       = result_ff.resume_hint;
   assign rsp_bus.activity_seen     = result_ff.activity_seen;

endmodule

`default_nettype wire
